// File: sv/crtl_pkg.sv
// ----------------------------------------------------------------------------
// crtl_pkg
// Shared types and constants of the code range table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package crtl_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int ADDRESS_BITS_DEF  = 48;

    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 48;
    localparam int LEN_W    = 12;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_MISMATCH  = 3'd4
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [ID_W-1:0]       found_id;
        logic [ADDR_W-1:0]     found_start;
        logic [LEN_W-1:0]      found_length;
        logic [USED_W-1:0]     entries_used;
    } t_result;

endpackage

`default_nettype wire

// File: sv/crtl_if.sv
// ----------------------------------------------------------------------------
// crtl_req_if / crtl_rsp_if
// Valid/ready channels for requests and results of the range table.
// ----------------------------------------------------------------------------
`default_nettype none

interface crtl_req_if
    import crtl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  range_length;
    logic [ID_W-1:0]   record_id;

    modport source (output valid, mode, address, range_length, record_id, input ready);
    modport sink   (input valid, mode, address, range_length, record_id, output ready);
endinterface

interface crtl_rsp_if
    import crtl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
    logic [ADDR_W-1:0]   found_start;
    logic [LEN_W-1:0]    found_length;
    logic [USED_W-1:0]   entries_used;

    modport source (output valid, status, found_id, found_start, found_length, entries_used,
                    input ready);
    modport sink   (input valid, status, found_id, found_start, found_length, entries_used,
                    output ready);
endinterface

`default_nettype wire

// File: sv/crtl_ram.sv
// ----------------------------------------------------------------------------
// crtl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/crtl_seq.sv
// ----------------------------------------------------------------------------
// crtl_seq
// Request sequencer: entry count, append, tail pop and binary search probes
// against the range table memory.
// ----------------------------------------------------------------------------
`default_nettype none

module crtl_seq
    import crtl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF,
    localparam int IW = $clog2(TABLE_ENTRIES),
    localparam int DW = ADDRESS_BITS + LEN_W + ID_W
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    crtl_req_if.sink            i_req,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output t_result             o_res,
    output logic                o_ram_we,
    output logic [IW-1:0]       o_ram_waddr,
    output logic [DW-1:0]       o_ram_wdata,
    output logic [IW-1:0]       o_ram_raddr,
    input  wire logic [DW-1:0]  i_ram_rdata
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PROBE = 6'b000010,
        S_CMP   = 6'b000100,
        S_TAIL  = 6'b001000,
        S_RMV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    t_result                 r_res, n_res;

    logic [63:0]             in_addr64;
    logic [ADDRESS_BITS-1:0] in_addr;
    logic [CW:0]             mid_sum;
    logic [CW:0]             mid_half;
    logic [IW-1:0]           mid;
    logic [CW-1:0]           tail_full;
    logic [IW-1:0]           tail;
    logic                    full;
    logic [ADDRESS_BITS-1:0] rd_start;
    logic [LEN_W-1:0]        rd_len;
    logic [ID_W-1:0]         rd_id;
    logic [63:0]             rd_start64;
    logic [ADDRESS_BITS-1:0] diff;
    logic                    start_le;
    logic                    hit;
    logic [31:0]             used32;

    assign in_addr64 = 64'(i_req.address);
    assign in_addr   = in_addr64[ADDRESS_BITS-1:0];

    // probe index: floor((lo + hi - 1) / 2)
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi} - (CW + 1)'(1);
    assign mid_half  = mid_sum >> 1;
    assign mid       = mid_half[IW-1:0];

    assign tail_full = r_count - CW'(1);
    assign tail      = tail_full[IW-1:0];
    assign full      = (r_count == CW'(TABLE_ENTRIES));

    assign rd_start   = i_ram_rdata[DW-1 -: ADDRESS_BITS];
    assign rd_len     = i_ram_rdata[ID_W +: LEN_W];
    assign rd_id      = i_ram_rdata[ID_W-1:0];
    assign rd_start64 = 64'(rd_start);
    assign diff       = r_addr - rd_start;
    assign start_le   = (rd_start <= r_addr);
    assign hit        = start_le && (diff < ADDRESS_BITS'(rd_len));

    assign o_ram_waddr = r_count[IW-1:0];
    assign o_ram_wdata = {in_addr, i_req.range_length, i_req.record_id};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_addr      = r_addr;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_raddr = mid;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_addr             = in_addr;
                    n_state            = S_DONE;
                    n_res.status       = ST_NOT_FOUND;
                    n_res.found_id     = '0;
                    n_res.found_start  = '0;
                    n_res.found_length = '0;
                    case (t_mode'(i_req.mode))
                        MODE_APPEND: begin
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_ram_we     = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_res.status = ST_OK;
                            end
                        end
                        MODE_LOOKUP: begin
                            if (r_count != '0) begin
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_state = S_PROBE;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_TAIL;
                            end
                        end
                        default: begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                o_ram_raddr = mid;
                n_state     = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_res.status       = ST_OK;
                    n_res.found_id     = rd_id;
                    n_res.found_start  = rd_start64[ADDR_W-1:0];
                    n_res.found_length = rd_len;
                    n_state            = S_DONE;
                end else begin
                    if (start_le) begin
                        n_lo = CW'(mid) + CW'(1);
                    end else begin
                        n_hi = CW'(mid);
                    end
                    if (n_lo < n_hi) begin
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TAIL: begin
                o_ram_raddr = tail;
                n_state     = S_RMV;
            end
            S_RMV: begin
                if (rd_start > r_addr) begin
                    n_res.status = ST_MISMATCH;
                end else begin
                    n_count            = r_count - CW'(1);
                    n_res.status       = ST_OK;
                    n_res.found_id     = rd_id;
                    n_res.found_start  = rd_start64[ADDR_W-1:0];
                    n_res.found_length = rd_len;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        used32             = 32'(n_count);
        n_res.entries_used = used32[USED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: sv/code_range_table_lookup.sv
// ----------------------------------------------------------------------------
// code_range_table_lookup
// Sorted code range table with append, binary search lookup and tail remove.
//
//   channel | dir | fields                                              | handshake
//   i_req   | in  | mode, address, range_length, record_id              | valid/ready
//   o_rsp   | out | status, found_id, found_start, found_length,        | valid/ready
//           |     | entries_used                                        |
//
// Append writes the new entry directly; remove reads and checks the tail; lookup
// makes p probes (at most floor(log2 n) + 1, 9 for 256 entries).
// Each probe is one table read plus one compare: the single read port of
// the table memory with its registered data sets the probe rate.
// Reset empties the table at once (entry count to zero); no clearing pass.
// A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module code_range_table_lookup
    import crtl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crtl_req_if.sink  i_req,
    crtl_rsp_if.source o_rsp
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int DW = ADDRESS_BITS + LEN_W + ID_W;

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic          r_out_valid;
    t_result       r_out;

    crtl_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    crtl_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.found_id     = r_out.found_id;
    assign o_rsp.found_start  = r_out.found_start;
    assign o_rsp.found_length = r_out.found_length;
    assign o_rsp.entries_used = r_out.entries_used;

endmodule

`default_nettype wire
